// ===== hdl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int WORD_W  = 32;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [WORD_W-1:0] NO_VALUE = -32'sd1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the request
    logic exec;     // evaluate the request, issue write or read
    logic capture;  // take read data, finish pop or peek
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;
  } dq_sts_t;

endpackage

// ===== hdl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Request sequencer: accept, execute, wait on the RAM read, report.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            done_o,
  output dq_pkg::dq_cmd_t cmd_o,
  input  dq_pkg::dq_sts_t sts_i
);
  import dq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = sts_i.need_read ? S_RDWAIT : S_RESP;
      end
      S_RDWAIT: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = (state_q == S_RESP);
  assign cmd_o.load    = (state_q == S_IDLE) && start;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.capture = (state_q == S_RDWAIT);

endmodule

// ===== hdl/dq_dpath.sv =====
// ----------------------------------------------------------------------------
// dq_dpath
// Ring indices, item count, entry store and result registers.
// ----------------------------------------------------------------------------
module dq_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dq_pkg::dq_cmd_t                  cmd_i,
  output dq_pkg::dq_sts_t                  sts_o,
  input  logic [dq_pkg::REQ_W-1:0]         req_type_i,
  input  logic signed [dq_pkg::WORD_W-1:0] push_value_i,
  output logic signed [dq_pkg::WORD_W-1:0] read_value_o,
  output logic [dq_pkg::STAT_W-1:0]        status_o,
  output logic [dq_pkg::TOTAL_W-1:0]       item_total_o
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // request registers
  logic [REQ_W-1:0]         req_q;
  logic [WORD_W-1:0]        val_q;

  // ring state
  logic [AW-1:0]            front_q, front_d;
  logic [CW-1:0]            count_q, count_d;

  // result registers
  logic [WORD_W-1:0]        res_val_q, res_val_d;
  logic [STAT_W-1:0]        res_st_q, res_st_d;
  logic                     res_load;

  logic                     is_push, is_read, at_front, full, empty;
  logic [AW-1:0]            front_dec, front_inc, tail_pos, back_pos;
  logic [CW:0]              tail_sum, back_sum;
  logic [CW+TOTAL_W-1:0]    total_ext;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;

  always_comb begin
    is_push  = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_PUSH_BACK);
    is_read  = req_q inside {[REQ_POP_FRONT:REQ_PEEK_BACK]};
    at_front = (req_q == REQ_POP_FRONT) || (req_q == REQ_PEEK_FRONT);
    full     = (count_q == CW'(DEPTH));
    empty    = (count_q == '0);

    front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
    front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

    // sums stay below twice the depth, so one conditional subtract wraps them
    tail_sum = (CW + 1)'(front_q) + (CW + 1)'(count_q);
    back_sum = tail_sum - (CW + 1)'(1);
    tail_pos = (tail_sum >= (CW + 1)'(DEPTH)) ? AW'(tail_sum - (CW + 1)'(DEPTH))
                                               : AW'(tail_sum);
    back_pos = (back_sum >= (CW + 1)'(DEPTH)) ? AW'(back_sum - (CW + 1)'(DEPTH))
                                               : AW'(back_sum);
  end

  assign sts_o.need_read = is_read && !empty;

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    res_val_d = NO_VALUE;
    res_st_d  = ST_OK;
    res_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = (req_q == REQ_PUSH_FRONT) ? front_dec : tail_pos;
    ram_re    = 1'b0;
    ram_raddr = at_front ? front_q : back_pos;

    if (cmd_i.exec) begin
      if (is_read) begin
        if (empty) begin
          res_st_d = ST_EMPTY;
          res_load = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end else begin
        res_load = 1'b1;
        if (is_push) begin
          if (full) begin
            res_st_d = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            count_d = count_q + CW'(1);
            if (req_q == REQ_PUSH_FRONT) front_d = front_dec;
          end
        end
      end
    end else if (cmd_i.capture) begin
      res_load  = 1'b1;
      res_val_d = ram_rdata;
      if (req_q == REQ_POP_FRONT) begin
        front_d = front_inc;
        count_d = count_q - CW'(1);
      end else if (req_q == REQ_POP_BACK) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      val_q <= push_value_i;
    end
    if (res_load) begin
      res_val_q <= res_val_d;
      res_st_q  <= res_st_d;
    end
  end

  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // count is final by the report cycle; show its low bits
  assign total_ext    = {{TOTAL_W{1'b0}}, count_q};
  assign item_total_o = total_ext[TOTAL_W-1:0];
  assign read_value_o = res_val_q;
  assign status_o     = res_st_q;

endmodule

// ===== hdl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words held in a ring RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its single result
// appears on read_value_o, status_o and item_total_o for one cycle with
// done_o high; the receiver cannot stall it, so sample on done_o. Pushes,
// no-ops and requests refused as empty or full go from accept through
// S_EXEC to S_RESP; pops and peeks also pass S_RDWAIT for the registered
// read of the entry RAM. busy falls in the cycle after done_o.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [dq_pkg::REQ_W-1:0]         req_type_i,
  input  logic signed [dq_pkg::WORD_W-1:0] push_value_i,
  output logic                             done_o,
  output logic signed [dq_pkg::WORD_W-1:0] read_value_o,
  output logic [dq_pkg::STAT_W-1:0]        status_o,
  output logic [dq_pkg::TOTAL_W-1:0]       item_total_o
);
  import dq_pkg::*;

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .item_total_o (item_total_o)
  );

endmodule

// ===== tb/double_ended_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer deque. A short scripted sequence
// covers the empty, full and unused-code cases and the word extremes. It is
// followed by random push/pop/peek traffic that fills and drains the ring
// many times. Every done_o strobe is checked against a scripted result or
// a behavioral copy of the deque.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int QDEPTH       = 16;
  localparam int RANDOM_ITEMS = 1822;
  localparam int STALL_LIMIT  = 500;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_GAP      = 12;

  // request codes the block treats as no-ops
  localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic [TOTAL_W-1:0]       total;
  } dq_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req;
    logic signed [WORD_W-1:0] word;
    int                       reps;
    bit                       typed;
    dq_result_t               result;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [REQ_W-1:0]         req_type_i;
  logic signed [WORD_W-1:0] push_value_i;
  logic                     done_o;
  logic signed [WORD_W-1:0] read_value_o;
  logic [STAT_W-1:0]        status_o;
  logic [TOTAL_W-1:0]       item_total_o;

  // behavioral deque state; the 4-bit head wraps at QDEPTH by itself
  logic signed [WORD_W-1:0] ring_words [QDEPTH];
  logic [3:0]               ring_head;
  logic [4:0]               ring_fill;

  dq_result_t pending_results[$];
  int         mismatches;
  int         stall_cycles;
  bit         steady;

  stim_row_t script [14] = '{
    '{REQ_POP_FRONT,  32'sd0,         1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
    '{REQ_POP_BACK,   32'sd0,         1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
    '{REQ_PEEK_FRONT, 32'sd0,         1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
    '{REQ_PEEK_BACK,  32'sd0,         1, 1'b1, '{NO_VALUE, ST_EMPTY, 5'd0}},
    '{REQ_UNUSED_A,   32'sd5,         1, 1'b1, '{NO_VALUE, ST_OK,    5'd0}},
    '{REQ_UNUSED_B,   -32'sd1,        1, 1'b1, '{NO_VALUE, ST_OK,    5'd0}},
    '{REQ_PUSH_FRONT, 32'h7fffffff,   1, 1'b1, '{NO_VALUE, ST_OK,    5'd1}},
    '{REQ_PUSH_BACK,  32'h80000000,   1, 1'b1, '{NO_VALUE, ST_OK,    5'd2}},
    '{REQ_PEEK_FRONT, 32'sd0,         1, 1'b1, '{32'h7fffffff, ST_OK, 5'd2}},
    '{REQ_PEEK_BACK,  32'sd0,         1, 1'b1, '{32'h80000000, ST_OK, 5'd2}},
    '{REQ_PUSH_BACK,  32'h5555aaaa,   7, 1'b0, '0},
    '{REQ_PUSH_FRONT, 32'haaaa5555,   7, 1'b0, '0},
    '{REQ_PUSH_BACK,  32'sd1,         1, 1'b1, '{NO_VALUE, ST_FULL,  5'd16}},
    '{REQ_PUSH_FRONT, 32'sd2,         1, 1'b1, '{NO_VALUE, ST_FULL,  5'd16}}
  };

  double_ended_queue #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .push_value_i(push_value_i),
    .done_o      (done_o),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .item_total_o(item_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic dq_result_t deque_apply(input logic [REQ_W-1:0] req,
                                             input logic signed [WORD_W-1:0] word);
    dq_result_t r;
    logic [3:0] slot;
    r.value  = NO_VALUE;
    r.status = ST_OK;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (ring_fill == 5'(QDEPTH)) begin
          r.status = ST_FULL;
        end else begin
          if (req == REQ_PUSH_FRONT) begin
            ring_head = ring_head - 4'd1;
            slot = ring_head;
          end else begin
            slot = ring_head + ring_fill[3:0];
          end
          ring_words[slot] = word;
          ring_fill = ring_fill + 5'd1;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (ring_fill == 5'd0) begin
          r.status = ST_EMPTY;
        end else begin
          if (req == REQ_POP_FRONT || req == REQ_PEEK_FRONT) slot = ring_head;
          else slot = ring_head + ring_fill[3:0] - 4'd1;
          r.value = ring_words[slot];
          if (req == REQ_POP_FRONT) begin
            ring_head = ring_head + 4'd1;
            ring_fill = ring_fill - 5'd1;
          end else if (req == REQ_POP_BACK) begin
            ring_fill = ring_fill - 5'd1;
          end
        end
      end
      default: ;
    endcase
    r.total = ring_fill;
    return r;
  endfunction

  function automatic int pick_gap();
    int n;
    n = 0;
    if (!steady) begin
      while (n < MAX_GAP && $urandom_range(99) < 34) n++;
    end
    return n;
  endfunction

  // push_bias steers the fill level so both full and empty are reached often
  function automatic logic [REQ_W-1:0] pick_request(input int push_bias);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return ($urandom_range(1) != 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
    if ($urandom_range(99) < push_bias)
      return ($urandom_range(1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    case ($urandom_range(7))
      0:       return REQ_PEEK_FRONT;
      1:       return REQ_PEEK_BACK;
      2, 3, 4: return REQ_POP_FRONT;
      default: return REQ_POP_BACK;
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // start stays high after a transfer; the next call retargets it in the
  // same step, or lowers it for an idle gap
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic signed [WORD_W-1:0] word,
                              input bit typed, input dq_result_t typed_result);
    int gap;
    dq_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    req_type_i   <= req;
    push_value_i <= word;
    do @(posedge clk_i); while (busy);
    predicted = deque_apply(req, word);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    dq_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.value)
          report_mismatch($sformatf("read_value %0d, expected %0d", read_value_o, want.value));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (item_total_o !== want.total)
          report_mismatch($sformatf("item_total %0d, expected %0d", item_total_o, want.total));
      end
    end
  end

  // stall watchdog: any transfer on either side restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR %0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int push_bias;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    req_type_i   <= REQ_PEEK_FRONT;
    push_value_i <= '0;
    mismatches   = 0;
    steady       = 1'b0;
    push_bias    = 50;
    ring_head    = '0;
    ring_fill    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++)
        send_request(script[i].req, script[i].word + k, script[i].typed,
                     script[i].result);
    end
    // pop both ends of the full ring, then let it settle completely
    send_request(REQ_POP_FRONT, pick_word(), 1'b0, '0);
    send_request(REQ_POP_BACK, pick_word(), 1'b0, '0);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 85;
          1:       push_bias = 15;
          default: push_bias = 50;
        endcase
      end
      steady = (n >= 400 && n < 700);
      if (n == 900) drain_results();
      send_request(pick_request(push_bias), pick_word(), 1'b0, '0);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_ctrl.sv
hdl/dq_dpath.sv
hdl/double_ended_queue.sv
tb/double_ended_queue_tb.sv
